### hdl/hhfv_pkg.sv
// Shared types, command and fault codes, and name tables for the header field validator.
// Used by every module under hdl/; depends on nothing.
package hhfv_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;

  // Command codes
  localparam logic [1:0] CMD_NAME  = 2'd0;
  localparam logic [1:0] CMD_VALUE = 2'd1;
  localparam logic [1:0] CMD_END   = 2'd2;

  // Fault codes, lowest wins
  localparam logic [2:0] FAULT_OK         = 3'd0;
  localparam logic [2:0] FAULT_NAME_CHAR  = 3'd1;
  localparam logic [2:0] FAULT_VALUE_CHAR = 3'd2;
  localparam logic [2:0] FAULT_EDGE_WS    = 3'd3;
  localparam logic [2:0] FAULT_CONN_HDR   = 3'd4;
  localparam logic [2:0] FAULT_TE_VALUE   = 3'd5;

  localparam int unsigned CONN_COUNT    = 8;
  localparam int unsigned TE_SLOT       = 4;
  localparam int unsigned CONN_STR_W    = 19 * 8;
  localparam logic [4:0]  NAME_POS_MAX  = 5'd31;
  localparam logic [3:0]  VALUE_POS_MAX = 4'd15;
  localparam logic [3:0]  TRAILERS_LEN  = 4'd8;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic       field_ok;
    logic [2:0] fault_code;
  } out_item_t;

  // One classified beat as it travels through the queue
  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] data_byte;
    logic       name_bad;
    logic       is_colon;
    logic       is_ws;
    logic       value_bad;
  } class_t;

  function automatic logic [4:0] conn_len(input logic [2:0] slot);
    logic [4:0] len;
    unique case (slot)
      3'd0:    len = 5'd10;
      3'd1:    len = 5'd10;
      3'd2:    len = 5'd18;
      3'd3:    len = 5'd19;
      3'd4:    len = 5'd2;
      3'd5:    len = 5'd8;
      3'd6:    len = 5'd17;
      default: len = 5'd7;
    endcase
    return len;
  endfunction

  // Byte at position pos of listed name slot; zero past its end
  function automatic logic [7:0] conn_char(input logic [2:0] slot, input logic [4:0] pos);
    logic [CONN_STR_W-1:0] s;
    logic [4:0]            len;
    logic [7:0]            ch;
    len = conn_len(slot);
    unique case (slot)
      3'd0:    s = CONN_STR_W'("connection");
      3'd1:    s = CONN_STR_W'("keep-alive");
      3'd2:    s = CONN_STR_W'("proxy-authenticate");
      3'd3:    s = CONN_STR_W'("proxy-authorization");
      3'd4:    s = CONN_STR_W'("te");
      3'd5:    s = CONN_STR_W'("trailers");
      3'd6:    s = CONN_STR_W'("transfer-encoding");
      default: s = CONN_STR_W'("upgrade");
    endcase
    ch = 8'h00;
    if (pos < len) begin
      ch = s[8 * (int'(len) - 1 - int'(pos)) +: 8];
    end
    return ch;
  endfunction

  function automatic logic [7:0] trailers_char(input logic [2:0] pos);
    logic [63:0] s;
    s = 64'("trailers");
    return s[8 * (7 - int'(pos)) +: 8];
  endfunction

endpackage

### hdl/hhfv_front.sv
// Front end: takes input beats, drops unused commands and classifies each byte.
// Depends on hhfv_pkg; feeds hhfv_queue.
module hhfv_front (
  input  logic                in_valid_i,
  input  hhfv_pkg::in_item_t  in_item_i,
  input  logic                q_full_i,
  output logic                in_stall_o,
  output logic                push_o,
  output hhfv_pkg::class_t    push_item_o
);

  logic [7:0] c;
  logic       known_cmd;

  assign c         = in_item_i.data_byte;
  assign known_cmd = (in_item_i.cmd == hhfv_pkg::CMD_NAME) ||
                     (in_item_i.cmd == hhfv_pkg::CMD_VALUE) ||
                     (in_item_i.cmd == hhfv_pkg::CMD_END);

  assign in_stall_o = q_full_i;
  // Drop the unused command at the door
  assign push_o     = in_valid_i && !q_full_i && known_cmd;

  always_comb begin
    push_item_o.cmd       = in_item_i.cmd;
    push_item_o.data_byte = c;
    push_item_o.name_bad  = (c <= 8'h20) || ((c >= 8'h41) && (c <= 8'h5A)) || (c >= 8'h7F);
    push_item_o.is_colon  = (c == 8'h3A);
    push_item_o.is_ws     = (c == 8'h20) || (c == 8'h09);
    push_item_o.value_bad = (c == 8'h00) || (c == 8'h0D) || (c == 8'h0A);
  end

endmodule

### hdl/hhfv_queue.sv
// Short FIFO of classified beats between the front end and the checker.
// Depends on hhfv_pkg for the entry type.
module hhfv_queue #(
  parameter int unsigned Depth = hhfv_pkg::QUEUE_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  hhfv_pkg::class_t push_item_i,
  input  logic             pop_i,
  output logic             full_o,
  output logic             valid_o,
  output hhfv_pkg::class_t head_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  hhfv_pkg::class_t entries_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == FullCnt);
  assign valid_o = (count_q != '0);
  assign head_o  = entries_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

### hdl/hhfv_back.sv
// Checker: folds classified beats into per-field state and registers one verdict per field.
// Depends on hhfv_pkg; drains hhfv_queue.
module hhfv_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_valid_i,
  input  hhfv_pkg::class_t    q_head_i,
  output logic                q_pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output hhfv_pkg::out_item_t out_item_o
);

  logic [4:0] name_pos_q, name_pos_d;
  logic       name_fault_q, name_fault_d;
  logic [7:0] match_q, match_d;
  logic [3:0] value_pos_q, value_pos_d;
  logic       value_fault_q, value_fault_d;
  logic       lead_ws_q, lead_ws_d;
  logic       last_ws_q, last_ws_d;
  logic       trl_match_q, trl_match_d;
  logic       out_valid_q, out_valid_d;
  hhfv_pkg::out_item_t out_item_q, out_item_d;

  logic       out_free, is_end, take;
  logic [7:0] c;
  logic [7:0] name_keep;
  logic       conn_hit, is_te;
  logic [2:0] code;

  assign c        = q_head_i.data_byte;
  assign out_free = !out_valid_q || !out_stall_i;
  assign is_end   = (q_head_i.cmd == hhfv_pkg::CMD_END);
  // Hold an end beat until the result register can take its verdict
  assign take     = q_valid_i && (!is_end || out_free);
  assign q_pop_o  = take;

  always_comb begin
    for (int i = 0; i < hhfv_pkg::CONN_COUNT; i++) begin
      name_keep[i] = match_q[i] && (name_pos_q < hhfv_pkg::conn_len(3'(i))) &&
                     (c == hhfv_pkg::conn_char(3'(i), name_pos_q));
    end
  end

  always_comb begin
    conn_hit = 1'b0;
    for (int i = 0; i < hhfv_pkg::CONN_COUNT; i++) begin
      if ((i != hhfv_pkg::TE_SLOT) && match_q[i] &&
          (name_pos_q == hhfv_pkg::conn_len(3'(i)))) begin
        conn_hit = 1'b1;
      end
    end
    is_te = match_q[hhfv_pkg::TE_SLOT] &&
            (name_pos_q == hhfv_pkg::conn_len(3'(hhfv_pkg::TE_SLOT)));
  end

  always_comb begin
    priority if (name_fault_q) begin
      code = hhfv_pkg::FAULT_NAME_CHAR;
    end else if (value_fault_q) begin
      code = hhfv_pkg::FAULT_VALUE_CHAR;
    end else if ((value_pos_q != '0) && (lead_ws_q || last_ws_q)) begin
      code = hhfv_pkg::FAULT_EDGE_WS;
    end else if (conn_hit) begin
      code = hhfv_pkg::FAULT_CONN_HDR;
    end else if (is_te && (value_pos_q != '0) &&
                 !(trl_match_q && (value_pos_q == hhfv_pkg::TRAILERS_LEN))) begin
      code = hhfv_pkg::FAULT_TE_VALUE;
    end else begin
      code = hhfv_pkg::FAULT_OK;
    end
  end

  always_comb begin
    name_pos_d    = name_pos_q;
    name_fault_d  = name_fault_q;
    match_d       = match_q;
    value_pos_d   = value_pos_q;
    value_fault_d = value_fault_q;
    lead_ws_d     = lead_ws_q;
    last_ws_d     = last_ws_q;
    trl_match_d   = trl_match_q;
    out_valid_d   = out_valid_q && out_stall_i;
    out_item_d    = out_item_q;
    if (take) begin
      unique case (q_head_i.cmd)
        hhfv_pkg::CMD_NAME: begin
          if (q_head_i.name_bad || (q_head_i.is_colon && (name_pos_q != '0))) begin
            name_fault_d = 1'b1;
          end
          match_d    = name_keep;
          name_pos_d = (name_pos_q == hhfv_pkg::NAME_POS_MAX) ? name_pos_q
                                                              : name_pos_q + 1'b1;
        end
        hhfv_pkg::CMD_VALUE: begin
          if (q_head_i.value_bad) begin
            value_fault_d = 1'b1;
          end
          if (value_pos_q == '0) begin
            lead_ws_d = q_head_i.is_ws;
          end
          last_ws_d = q_head_i.is_ws;
          if (!((value_pos_q < hhfv_pkg::TRAILERS_LEN) &&
                (c == hhfv_pkg::trailers_char(value_pos_q[2:0])))) begin
            trl_match_d = 1'b0;
          end
          value_pos_d = (value_pos_q == hhfv_pkg::VALUE_POS_MAX) ? value_pos_q
                                                                 : value_pos_q + 1'b1;
        end
        default: begin
          // End of field: register the verdict and clear for the next field
          out_valid_d           = 1'b1;
          out_item_d.field_ok   = (code == hhfv_pkg::FAULT_OK);
          out_item_d.fault_code = code;
          name_pos_d    = '0;
          name_fault_d  = 1'b0;
          match_d       = '1;
          value_pos_d   = '0;
          value_fault_d = 1'b0;
          lead_ws_d     = 1'b0;
          last_ws_d     = 1'b0;
          trl_match_d   = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      name_pos_q    <= '0;
      name_fault_q  <= 1'b0;
      match_q       <= '1;
      value_pos_q   <= '0;
      value_fault_q <= 1'b0;
      lead_ws_q     <= 1'b0;
      last_ws_q     <= 1'b0;
      trl_match_q   <= 1'b1;
      out_valid_q   <= 1'b0;
    end else begin
      name_pos_q    <= name_pos_d;
      name_fault_q  <= name_fault_d;
      match_q       <= match_d;
      value_pos_q   <= value_pos_d;
      value_fault_q <= value_fault_d;
      lead_ws_q     <= lead_ws_d;
      last_ws_q     <= last_ws_d;
      trl_match_q   <= trl_match_d;
      out_valid_q   <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_item_q <= out_item_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

### hdl/http2_header_field_validator.sv
// Top level of the HTTP/2 header field validator: front end, beat queue and checker.
// Depends on hhfv_pkg, hhfv_front, hhfv_queue and hhfv_back.
//
//   channel | direction | handshake             | beat
//   --------+-----------+-----------------------+----------------------------------
//   in      | sink      | in_valid_i/in_stall_o   | in_item_i  (cmd, data_byte)
//   out     | source    | out_valid_o/out_stall_i | out_item_o (field_ok, fault_code)
//
// One beat per cycle is accepted while the beat queue is not full; each byte only updates
// flags and match bits. After its end beat is accepted, a verdict passes through the queue
// entry and then into the result register.
// in_stall_o rises only when the beat queue is full: an end beat waits at the queue head while
// out_stall_i holds the result register, and the beats behind it fill the QueueDepth entries.
// Reset clears the queue, the field state and the result valid; no clearing pass.
module http2_header_field_validator #(
  parameter int unsigned QueueDepth = hhfv_pkg::QUEUE_DEPTH
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  hhfv_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output hhfv_pkg::out_item_t out_item_o
);

  logic             q_full, q_push, q_pop, q_valid;
  hhfv_pkg::class_t q_push_item, q_head;

  hhfv_front u_front (
    .in_valid_i  (in_valid_i),
    .in_item_i   (in_item_i),
    .q_full_i    (q_full),
    .in_stall_o  (in_stall_o),
    .push_o      (q_push),
    .push_item_o (q_push_item)
  );

  hhfv_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_item_i (q_push_item),
    .pop_i       (q_pop),
    .full_o      (q_full),
    .valid_o     (q_valid),
    .head_o      (q_head)
  );

  hhfv_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_head_i    (q_head),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

### tb/http2_header_field_validator_test.sv
// Self-checking testbench for http2_header_field_validator: streams header fields
// byte by byte, predicts each verdict and checks it against the output channel.
// Depends on hhfv_pkg and the RTL under hdl/.
module http2_header_field_validator_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int unsigned PHASE_FIELD_BEATS = 380;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  hhfv_pkg::in_item_t  in_item_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  hhfv_pkg::out_item_t out_item_o;

  hhfv_pkg::in_item_t  pending_beats[$];
  hhfv_pkg::out_item_t expected_verdicts[$];
  int unsigned pushed_beats = 0;
  int unsigned accepted_beats = 0;
  int unsigned field_beats = 0;
  int unsigned mismatch_count = 0;
  int unsigned sender_idle_pct = 0;
  int unsigned receiver_stall_pct = 0;

  // Field state mirrored from the block
  logic [4:0] name_len_seen = '0;
  logic       name_char_bad = 1'b0;
  logic [7:0] listed_candidates = 8'hFF;
  logic [3:0] value_len_seen = '0;
  logic       value_char_bad = 1'b0;
  logic       value_leads_ws = 1'b0;
  logic       value_ends_ws = 1'b0;
  logic       value_trailers_prefix = 1'b1;

  http2_header_field_validator dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  always #1 clk_i = ~clk_i;

  function automatic string listed_name(input int slot);
    case (slot)
      0: return "connection";
      1: return "keep-alive";
      2: return "proxy-authenticate";
      3: return "proxy-authorization";
      4: return "te";
      5: return "trailers";
      6: return "transfer-encoding";
      default: return "upgrade";
    endcase
  endfunction

  task automatic clear_field_state();
    name_len_seen = '0;
    name_char_bad = 1'b0;
    listed_candidates = 8'hFF;
    value_len_seen = '0;
    value_char_bad = 1'b0;
    value_leads_ws = 1'b0;
    value_ends_ws = 1'b0;
    value_trailers_prefix = 1'b1;
  endtask

  task automatic track_name_byte(input logic [7:0] c);
    string nm;
    if (c <= 8'h20 || (c >= 8'h41 && c <= 8'h5A) || c >= 8'h7F ||
        (c == 8'h3A && name_len_seen != 0)) begin
      name_char_bad = 1'b1;
    end
    for (int slot = 0; slot < hhfv_pkg::CONN_COUNT; slot++) begin
      nm = listed_name(slot);
      if (listed_candidates[slot] &&
          !(name_len_seen < nm.len() && c == nm.getc(name_len_seen))) begin
        listed_candidates[slot] = 1'b0;
      end
    end
    if (name_len_seen != hhfv_pkg::NAME_POS_MAX) name_len_seen = name_len_seen + 1'b1;
  endtask

  task automatic track_value_byte(input logic [7:0] c);
    string word;
    logic  ws;
    word = listed_name(5);
    ws = (c == 8'h20 || c == 8'h09);
    if (c == 8'h00 || c == 8'h0D || c == 8'h0A) value_char_bad = 1'b1;
    if (value_len_seen == 0) value_leads_ws = ws;
    value_ends_ws = ws;
    if (value_trailers_prefix &&
        !(value_len_seen < 8 && c == word.getc(value_len_seen))) begin
      value_trailers_prefix = 1'b0;
    end
    if (value_len_seen != hhfv_pkg::VALUE_POS_MAX) value_len_seen = value_len_seen + 1'b1;
  endtask

  function automatic hhfv_pkg::out_item_t field_verdict();
    hhfv_pkg::out_item_t v;
    logic [2:0]          code;
    string               nm;
    logic                te_name;
    code = hhfv_pkg::FAULT_OK;
    if (name_char_bad) begin
      code = hhfv_pkg::FAULT_NAME_CHAR;
    end else if (value_char_bad) begin
      code = hhfv_pkg::FAULT_VALUE_CHAR;
    end else if (value_len_seen != 0 && (value_leads_ws || value_ends_ws)) begin
      code = hhfv_pkg::FAULT_EDGE_WS;
    end else begin
      for (int slot = 0; slot < hhfv_pkg::CONN_COUNT; slot++) begin
        nm = listed_name(slot);
        if (slot != hhfv_pkg::TE_SLOT && listed_candidates[slot] &&
            name_len_seen == nm.len()) begin
          code = hhfv_pkg::FAULT_CONN_HDR;
        end
      end
      te_name = listed_candidates[hhfv_pkg::TE_SLOT] && name_len_seen == 2;
      if (code == hhfv_pkg::FAULT_OK && te_name && value_len_seen != 0 &&
          !(value_trailers_prefix && value_len_seen == 8)) begin
        code = hhfv_pkg::FAULT_TE_VALUE;
      end
    end
    v.fault_code = code;
    v.field_ok = (code == hhfv_pkg::FAULT_OK);
    return v;
  endfunction

  task automatic track_beat(input hhfv_pkg::in_item_t beat);
    case (beat.cmd)
      hhfv_pkg::CMD_NAME: track_name_byte(beat.data_byte);
      hhfv_pkg::CMD_VALUE: track_value_byte(beat.data_byte);
      hhfv_pkg::CMD_END: begin
        expected_verdicts.push_back(field_verdict());
        clear_field_state();
      end
      default: ;
    endcase
  endtask

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    $display("%0t ns: %s", $realtime, msg);
  endtask

  task automatic check_verdict(input hhfv_pkg::out_item_t got);
    hhfv_pkg::out_item_t want;
    if (expected_verdicts.size() == 0) begin
      report_mismatch($sformatf("unexpected verdict ok=%0b code=%0d",
                                got.field_ok, got.fault_code));
    end else begin
      want = expected_verdicts.pop_front();
      if (got.field_ok !== want.field_ok) begin
        report_mismatch($sformatf("field_ok got %0b want %0b", got.field_ok, want.field_ok));
      end
      if (got.fault_code !== want.fault_code) begin
        report_mismatch($sformatf("fault_code got %0d want %0d",
                                  got.fault_code, want.fault_code));
      end
    end
  endtask

  // Input side: track each accepted beat, then load the next one or idle
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_item_i <= '0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        track_beat(in_item_i);
        accepted_beats++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (pending_beats.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          in_valid_i <= 1'b1;
          in_item_i <= pending_beats.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Output side: check each accepted verdict and stall at random
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) check_verdict(out_item_o);
      out_stall_i <= ($urandom_range(99) < receiver_stall_pct);
    end
  end

  task automatic push_beat(input logic [1:0] cmd, input logic [7:0] data);
    hhfv_pkg::in_item_t beat;
    beat.cmd = cmd;
    beat.data_byte = data;
    pending_beats.push_back(beat);
    pushed_beats++;
    if (cmd != CMD_UNUSED) field_beats++;
  endtask

  task automatic push_text(input logic [1:0] cmd, input string s);
    for (int i = 0; i < s.len(); i++) push_beat(cmd, s.getc(i));
  endtask

  function automatic logic [7:0] legal_name_char();
    logic [7:0] c;
    if ($urandom_range(9) < 7) return 8'h61 + 8'($urandom_range(25));
    do begin
      c = 8'($urandom_range(8'h7E, 8'h21));
    end while ((c >= 8'h41 && c <= 8'h5A) || c == 8'h3A);
    return c;
  endfunction

  function automatic logic [7:0] visible_char();
    return 8'($urandom_range(8'h7E, 8'h21));
  endfunction

  task automatic add_random_field();
    logic [7:0] nm[$];
    logic [7:0] val[$];
    string      base;
    int         kind;
    int         vkind;
    int         len;
    int         slot;
    int         p;
    int         split;
    logic [7:0] ws;
    kind = $urandom_range(9);
    slot = -1;
    case (kind)
      0, 1, 2: begin
        slot = $urandom_range(7);
        base = listed_name(slot);
        for (int i = 0; i < base.len(); i++) nm.push_back(base.getc(i));
        p = $urandom_range(nm.size() - 1);
        case ($urandom_range(5))
          0: void'(nm.pop_back());
          1: nm.push_back(legal_name_char());
          2: nm[p] = legal_name_char();
          3: if (nm[p] >= 8'h61 && nm[p] <= 8'h7A) nm[p] = nm[p] - 8'h20;
          default: ;
        endcase
      end
      3: begin
        nm.push_back(8'h3A);
        len = $urandom_range(8, 1);
        for (int i = 0; i < len; i++) nm.push_back(legal_name_char());
      end
      4, 5, 6: begin
        len = $urandom_range(12);
        for (int i = 0; i < len; i++) nm.push_back(legal_name_char());
      end
      7: begin
        len = $urandom_range(40, 25);
        for (int i = 0; i < len; i++) nm.push_back(legal_name_char());
      end
      8: begin
        len = $urandom_range(8, 1);
        for (int i = 0; i < len; i++) nm.push_back(8'($urandom_range(255)));
      end
      default: begin
        len = $urandom_range(8, 2);
        for (int i = 0; i < len; i++) nm.push_back(legal_name_char());
        nm[$urandom_range(len - 1, 1)] = 8'h3A;
      end
    endcase

    // Lean toward trailers-like values when the name is te
    vkind = (slot == hhfv_pkg::TE_SLOT && $urandom_range(1)) ? 1 : $urandom_range(9);
    case (vkind)
      0: ;
      1, 2: begin
        base = listed_name(5);
        for (int i = 0; i < base.len(); i++) val.push_back(base.getc(i));
        case ($urandom_range(4))
          1: begin
            len = $urandom_range(7, 1);
            for (int i = 0; i < len; i++) void'(val.pop_back());
          end
          2: val.push_back(visible_char());
          3: val[$urandom_range(7)] = visible_char();
          4: val[0] = 8'h54;
          default: ;
        endcase
      end
      3, 4, 5: begin
        len = $urandom_range(10, 1);
        for (int i = 0; i < len; i++) val.push_back(visible_char());
        if (len > 2 && $urandom_range(1)) val[$urandom_range(len - 2, 1)] = 8'h20;
      end
      6: begin
        ws = $urandom_range(1) ? 8'h20 : 8'h09;
        len = $urandom_range(6);
        for (int i = 0; i < len; i++) val.push_back(visible_char());
        case ($urandom_range(2))
          0: val.push_front(ws);
          1: val.push_back(ws);
          default: begin
            val.push_front(ws);
            val.push_back(ws);
          end
        endcase
      end
      7: begin
        len = $urandom_range(6, 1);
        for (int i = 0; i < len; i++) val.push_back(visible_char());
        case ($urandom_range(2))
          0: val[$urandom_range(len - 1)] = 8'h00;
          1: val[$urandom_range(len - 1)] = 8'h0D;
          default: val[$urandom_range(len - 1)] = 8'h0A;
        endcase
      end
      8: begin
        len = $urandom_range(6, 1);
        for (int i = 0; i < len; i++) val.push_back(8'($urandom_range(255)));
      end
      default: begin
        len = $urandom_range(24, 14);
        for (int i = 0; i < len; i++) val.push_back(visible_char());
      end
    endcase

    // Mostly name then value; sometimes put name bytes after some value bytes
    split = ($urandom_range(7) == 0) ? $urandom_range(val.size()) : 0;
    for (int i = 0; i < split; i++) push_beat(hhfv_pkg::CMD_VALUE, val[i]);
    foreach (nm[i]) push_beat(hhfv_pkg::CMD_NAME, nm[i]);
    for (int i = split; i < val.size(); i++) push_beat(hhfv_pkg::CMD_VALUE, val[i]);
    if ($urandom_range(11) == 0) push_beat(CMD_UNUSED, 8'($urandom_range(255)));
    push_beat(hhfv_pkg::CMD_END, 8'($urandom_range(255)));
  endtask

  task automatic wait_drained();
    while (accepted_beats != pushed_beats || expected_verdicts.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  initial begin
    int unsigned target;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // te with trailers, te with empty value
    push_text(hhfv_pkg::CMD_NAME, "te");
    push_text(hhfv_pkg::CMD_VALUE, "trailers");
    push_beat(hhfv_pkg::CMD_END, 8'h00);
    push_text(hhfv_pkg::CMD_NAME, "te");
    push_beat(hhfv_pkg::CMD_END, 8'hFF);
    // extreme bytes: name 0xFF, value NUL
    push_beat(hhfv_pkg::CMD_NAME, 8'hFF);
    push_beat(hhfv_pkg::CMD_VALUE, 8'h00);
    push_beat(hhfv_pkg::CMD_END, 8'h00);
    // value that is a lone tab
    push_beat(hhfv_pkg::CMD_NAME, 8'h78);
    push_beat(hhfv_pkg::CMD_VALUE, 8'h09);
    push_beat(hhfv_pkg::CMD_END, 8'h00);
    // unused command, then a field with empty name and value
    push_beat(CMD_UNUSED, 8'hFF);
    push_beat(hhfv_pkg::CMD_END, 8'h00);
    // uppercase name byte
    push_beat(hhfv_pkg::CMD_NAME, 8'h41);
    push_beat(hhfv_pkg::CMD_END, 8'h00);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          sender_idle_pct = 0;
          receiver_stall_pct = 0;
        end
        1: begin
          sender_idle_pct = 85;
          receiver_stall_pct = 0;
        end
        2: begin
          sender_idle_pct = 0;
          receiver_stall_pct = 85;
        end
        default: begin
          sender_idle_pct = 11;
          receiver_stall_pct = 11;
        end
      endcase
      target = field_beats + PHASE_FIELD_BEATS;
      while (field_beats < target) add_random_field();
      wait_drained();
    end

    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("http2_header_field_validator: match");
    end else begin
      $display("http2_header_field_validator: mismatch");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("http2_header_field_validator: mismatch");
    $finish;
  end

endmodule
